>>> sv/sdhil_pkg.sv
// Shared types and constants of the signed decimal / hex integer lexer.
package sdhil_pkg;

	// Field widths of the stream payloads
	localparam int BYTE_W   = 8;
	localparam int NUMBER_W = 64;
	localparam int COUNT_W  = 9;
	localparam int STATUS_W = 2;

	// Longest literal in bytes; the count saturates one above this
	localparam int TOKEN_LIMIT = 255;

	// Padded width of the result tdata (number, consumed, then zero fill)
	localparam int RES_DATA_W = ((NUMBER_W + COUNT_W + 7) / 8) * 8;

	// Characters the lexer looks for
	localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [BYTE_W-1:0] CH_X     = 8'h78;
	localparam logic [BYTE_W-1:0] CH_0     = 8'h30;
	localparam logic [BYTE_W-1:0] CH_9     = 8'h39;
	localparam logic [BYTE_W-1:0] CH_UA    = 8'h41;
	localparam logic [BYTE_W-1:0] CH_UF    = 8'h46;
	localparam logic [BYTE_W-1:0] CH_LA    = 8'h61;
	localparam logic [BYTE_W-1:0] CH_LF    = 8'h66;

	// Result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_OK         = 2'd0,
		ST_INCOMPLETE = 2'd1,
		ST_UNEXPECTED = 2'd2,
		ST_TOO_LONG   = 2'd3
	} status_t;

	// One result item
	typedef struct packed {
		status_t               status;
		logic [NUMBER_W-1:0]   number;
		logic [COUNT_W-1:0]    consumed;
	} result_t;

endpackage

>>> sv/signed_dec_hex_integer_lexer.sv
// Integer literal lexer: optional minus, then decimal digits or 0x and hex digits.
// The result for the byte or end mark that closes the literal is registered in the output
// register, or in the skid entry while the output register holds a result not yet taken.
// Throughput: one input request per cycle; a two-entry output buffer lets input
// continue while a result waits, and input stalls only while both entries are full.
// Reset (arst_n low): lexer returns to idle with cleared state, output buffer empty.
module signed_dec_hex_integer_lexer #(
	parameter int VALUE_BITS = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// input request
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [sdhil_pkg::BYTE_W-1:0]       s_tdata,   // [7:0] text_byte
	input  logic                               s_tuser,   // [0] end_mark
	// result request
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [sdhil_pkg::RES_DATA_W-1:0]   m_tdata,   // [63:0] number, [72:64] consumed
	output logic [sdhil_pkg::STATUS_W-1:0]     m_tuser    // [1:0] status
);
	import sdhil_pkg::*;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_NEG   = 3'd1,
		PH_ZERO  = 3'd2,
		PH_ZEROX = 3'd3,
		PH_DEC   = 3'd4,
		PH_HEX   = 3'd5
	} phase_t;

	localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(TOKEN_LIMIT + 1);
	localparam logic [COUNT_W-1:0] COUNT_LIM = COUNT_W'(TOKEN_LIMIT);

	phase_t                  phase_q, phase_d;
	logic                    negative_q, negative_d;
	logic [VALUE_BITS-1:0]   accum_q, accum_d;
	logic [COUNT_W-1:0]      count_q, count_d;

	result_t                 out_q, skid_q, res;
	logic                    out_valid_q, skid_valid_q;
	logic                    res_valid;

	logic                    accept, take;
	logic [BYTE_W-1:0]       c;
	logic                    end_mark;
	logic                    is_dec, is_hex_alpha, is_hex;
	logic [3:0]              dig_dec, dig_hex;
	logic [COUNT_W-1:0]      count_inc;
	logic [VALUE_BITS-1:0]   acc_mul10, acc_mul16;

	// emit request from the phase logic
	logic                    emit;
	status_t                 emit_status;
	logic [COUNT_W-1:0]      emit_count;
	logic                    emit_zero_acc;
	logic [VALUE_BITS-1:0]   emit_acc, emit_val;

	assign accept   = s_tvalid && s_tready;
	assign take     = m_tvalid && m_tready;
	assign s_tready = !skid_valid_q;

	assign c        = s_tdata;
	assign end_mark = s_tuser;

	// Classify the byte
	assign is_dec       = (c >= CH_0) && (c <= CH_9);
	assign is_hex_alpha = ((c >= CH_UA) && (c <= CH_UF)) || ((c >= CH_LA) && (c <= CH_LF));
	assign is_hex       = is_dec || is_hex_alpha;
	assign dig_dec      = c[3:0];
	assign dig_hex      = is_hex_alpha ? 4'(c[3:0] + 4'd9) : c[3:0];

	// Saturating length count and accumulator shift-add
	assign count_inc = (count_q < COUNT_MAX) ? COUNT_W'(count_q + 1'b1) : count_q;
	assign acc_mul10 = (accum_q << 3) + (accum_q << 1) + VALUE_BITS'(dig_dec);
	assign acc_mul16 = (accum_q << 4) + VALUE_BITS'(dig_hex);

	// Next lexer state and emit request
	always_comb begin
		phase_d       = phase_q;
		negative_d    = negative_q;
		accum_d       = accum_q;
		count_d       = count_q;
		emit          = 1'b0;
		emit_status   = ST_OK;
		emit_count    = count_q;
		emit_zero_acc = 1'b0;
		unique case (phase_q)
			PH_IDLE, PH_NEG: begin
				if (end_mark) begin
					emit        = 1'b1;
					emit_status = ST_INCOMPLETE;
				end else if (phase_q == PH_IDLE && c == CH_MINUS) begin
					negative_d = 1'b1;
					count_d    = count_inc;
					phase_d    = PH_NEG;
				end else if (is_dec) begin
					count_d = count_inc;
					accum_d = VALUE_BITS'(dig_dec);
					phase_d = (dig_dec == 4'd0) ? PH_ZERO : PH_DEC;
				end else begin
					emit        = 1'b1;
					emit_status = (phase_q == PH_NEG) ? ST_UNEXPECTED : ST_OK;
				end
			end
			PH_ZERO: begin
				if (end_mark) begin
					emit = 1'b1;
				end else if (c == CH_X) begin
					count_d = count_inc;
					phase_d = PH_ZEROX;
				end else if (is_dec) begin
					count_d = count_inc;
					accum_d = VALUE_BITS'(dig_dec);
					phase_d = PH_DEC;
				end else begin
					emit = 1'b1;
				end
			end
			PH_ZEROX: begin
				if (end_mark) begin
					// prefix cut short: decimal zero, drop the x from the count
					emit          = 1'b1;
					emit_zero_acc = 1'b1;
					emit_count    = COUNT_W'(count_q - 1'b1);
				end else if (is_hex) begin
					count_d = count_inc;
					accum_d = VALUE_BITS'(dig_hex);
					phase_d = PH_HEX;
				end else begin
					emit        = 1'b1;
					emit_status = ST_UNEXPECTED;
				end
			end
			PH_DEC: begin
				if (!end_mark && is_dec) begin
					count_d = count_inc;
					accum_d = acc_mul10;
				end else begin
					emit = 1'b1;
				end
			end
			PH_HEX: begin
				if (!end_mark && is_hex) begin
					count_d = count_inc;
					accum_d = acc_mul16;
				end else begin
					emit = 1'b1;
				end
			end
			default: begin
				phase_d    = PH_IDLE;
				negative_d = 1'b0;
				accum_d    = '0;
				count_d    = '0;
			end
		endcase
		// return to idle after a result
		if (emit) begin
			phase_d    = PH_IDLE;
			negative_d = 1'b0;
			accum_d    = '0;
			count_d    = '0;
		end
	end

	// Build the result item
	assign emit_acc = emit_zero_acc ? '0 : accum_q;
	assign emit_val = negative_q ? VALUE_BITS'(-emit_acc) : emit_acc;

	always_comb begin
		res.consumed = emit_count;
		res.status   = emit_status;
		res.number   = '0;
		if (emit_status == ST_OK && emit_count > COUNT_LIM) begin
			res.status = ST_TOO_LONG;
		end else if (emit_status == ST_OK) begin
			res.number = NUMBER_W'($signed(emit_val));
		end
	end

	assign res_valid = accept && emit;

	// Lexer state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			negative_q <= 1'b0;
			accum_q    <= '0;
			count_q    <= '0;
		end else if (accept) begin
			phase_q    <= phase_d;
			negative_q <= negative_d;
			accum_q    <= accum_d;
			count_q    <= count_d;
		end
	end

	// Output register with skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (!out_valid_q || take) begin
			out_valid_q <= res_valid;
		end else if (res_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) begin
				out_q <= skid_q;
			end
		end else if (!out_valid_q || take) begin
			if (res_valid) begin
				out_q <= res;
			end
		end else if (res_valid) begin
			skid_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.status;
	assign m_tdata  = RES_DATA_W'({out_q.consumed, out_q.number});

endmodule
